>>> rtl/lsqt_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and helpers for the load/store queue timing block
// no dependencies

package lsqt_pkg;

    localparam int LOAD_ENTRIES  = 8;
    localparam int STORE_ENTRIES = 8;

    localparam int TIME_W = 48;
    localparam int LAT_W  = 16;
    localparam int ADDR_W = 48;
    localparam int OP_W   = 3;

    localparam int LQ_IDX_W = (LOAD_ENTRIES > 1) ? $clog2(LOAD_ENTRIES) : 1;
    localparam int SQ_IDX_W = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;

    localparam logic [LQ_IDX_W-1:0] LQ_LAST = LQ_IDX_W'(LOAD_ENTRIES - 1);
    localparam logic [SQ_IDX_W-1:0] SQ_LAST = SQ_IDX_W'(STORE_ENTRIES - 1);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [TIME_W-1:0] time_t;

    localparam time_t TIME_MAX = '1;
    localparam time_t TIME_ONE = TIME_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_STORE  = 3'd1,
        OP_LFENCE = 3'd2,
        OP_SFENCE = 3'd3,
        OP_FENCE  = 3'd4
    } op_t;

    typedef enum logic [CFG_ADDR_W-3:0] {
        REG_SPECULATIVE_LOADS = 1'b0,
        REG_PARALLEL_STORES   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_ISSUE,
        ST_SUM,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic capture;
        logic step_alloc;
        logic step_issue;
        logic step_sum;
        logic commit;
    } lsqt_cmd_t;

    function automatic time_t sat_add(time_t a, time_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic time_t tmax(time_t a, time_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/lsqt_ctrl.sv
`timescale 1ns / 1ps
// sequencing controller: walks each request through alloc, issue, sum and commit
// depends on lsqt_pkg

module lsqt_ctrl import lsqt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output lsqt_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_ALLOC;
            ST_ALLOC: state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_SUM;
            ST_SUM:   state_next = ST_FINAL;
            ST_FINAL: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.capture = s_valid;
            end
            ST_ALLOC: cmd.step_alloc = 1'b1;
            ST_ISSUE: cmd.step_issue = 1'b1;
            ST_SUM:   cmd.step_sum = 1'b1;
            ST_FINAL: cmd.commit = out_free;
            default:  cmd = '0;
        endcase
    end

    // result register is refilled on commit, drained by the consumer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

>>> rtl/lsqt_datapath.sv
`timescale 1ns / 1ps
// datapath: queue rings, store address match, timing arithmetic, result register
// depends on lsqt_pkg

module lsqt_datapath import lsqt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsqt_cmd_t         cmd,
    input  logic              speculative_loads,
    input  logic              parallel_store_ownership,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [TIME_W-1:0] s_request_time,
    input  logic [LAT_W-1:0]  s_latency,
    input  logic [ADDR_W-1:0] s_address,
    output logic [TIME_W-1:0] m_grant_time,
    output logic [TIME_W-1:0] m_finish_time,
    output logic [TIME_W-1:0] m_release_time,
    output logic              m_forwarded
);

    // queue state
    time_t               lrel_reg [LOAD_ENTRIES];
    time_t               srel_reg [STORE_ENTRIES];
    logic [ADDR_W-1:0]   saddr_reg [STORE_ENTRIES];
    logic [STORE_ENTRIES-1:0] svalid_reg;
    logic [LQ_IDX_W-1:0] lslot_reg;
    logic [SQ_IDX_W-1:0] sslot_reg;
    time_t               lfence_reg, sfence_reg;
    time_t               last_lrel_reg, last_srel_reg;

    // request capture
    logic [OP_W-1:0]   op_reg;
    time_t             req_reg;
    logic [LAT_W-1:0]  lat_reg;
    logic [ADDR_W-1:0] addr_reg;

    // working registers
    time_t alloc_reg, prevl_reg, prevs_reg;
    time_t issue_reg, pm_reg, prevl_p1_reg, alloc_p1_reg, sum_reg;
    logic  fwd_reg;

    // result register
    time_t res_alloc_reg, res_comp_reg, res_rel_reg;
    logic  res_fwd_reg;

    logic  is_load, is_store;
    time_t alloc_next, slot_rel;
    logic  hit;
    time_t sum_base, sum_lat, sum_next;
    time_t res_alloc_next, res_comp_next, res_rel_next;
    logic  res_fwd_next;

    assign is_load  = (op_t'(op_reg) == OP_LOAD);
    assign is_store = (op_t'(op_reg) == OP_STORE);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_operation;
            req_reg  <= s_request_time;
            lat_reg  <= s_latency;
            addr_reg <= s_address;
        end
    end

    // alloc step: slot release plus one, no earlier than the request
    assign slot_rel   = is_load ? lrel_reg[lslot_reg] : srel_reg[sslot_reg];
    assign alloc_next = tmax(sat_add(slot_rel, TIME_ONE), req_reg);

    // store match against every entry still live at the load's alloc time
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < STORE_ENTRIES; i++) begin
            if (svalid_reg[i] && saddr_reg[i] == addr_reg && srel_reg[i] >= alloc_reg) begin
                hit = 1'b1;
            end
        end
    end

    // sum step: pick the base the mode calls for and add the latency, or one for a forwarded load
    always_comb begin
        sum_base = issue_reg;
        if (is_load && !speculative_loads) begin
            sum_base = tmax(issue_reg, prevl_reg);
        end else if (is_store && !parallel_store_ownership) begin
            sum_base = tmax(issue_reg, pm_reg);
        end
        sum_lat  = fwd_reg ? TIME_ONE : {{(TIME_W-LAT_W){1'b0}}, lat_reg};
        sum_next = sat_add(sum_base, sum_lat);
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_alloc) begin
            alloc_reg <= alloc_next;
            prevl_reg <= last_lrel_reg;
            prevs_reg <= last_srel_reg;
        end
        if (cmd.step_issue) begin
            issue_reg    <= tmax(alloc_reg, is_load ? lfence_reg : sfence_reg);
            fwd_reg      <= is_load && hit;
            pm_reg       <= tmax(prevl_reg, prevs_reg);
            prevl_p1_reg <= sat_add(prevl_reg, TIME_ONE);
            alloc_p1_reg <= sat_add(alloc_reg, TIME_ONE);
        end
        if (cmd.step_sum) begin
            sum_reg <= sum_next;
        end
    end

    // final step: result fields
    always_comb begin
        res_alloc_next = '0;
        res_comp_next  = '0;
        res_rel_next   = '0;
        res_fwd_next   = 1'b0;
        case (op_t'(op_reg))
            OP_LOAD: begin
                res_alloc_next = alloc_reg;
                res_fwd_next   = fwd_reg;
                res_rel_next   = speculative_loads ? tmax(sum_reg, prevl_p1_reg) : sum_reg;
                res_comp_next  = fwd_reg ? alloc_p1_reg : sum_reg;
            end
            OP_STORE: begin
                res_alloc_next = alloc_reg;
                res_rel_next   = parallel_store_ownership ?
                                 sat_add(tmax(sum_reg, pm_reg), TIME_ONE) : sum_reg;
                res_comp_next  = res_rel_next;
            end
            default: begin
                res_alloc_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_alloc_reg <= res_alloc_next;
            res_comp_reg  <= res_comp_next;
            res_rel_reg   <= res_rel_next;
            res_fwd_reg   <= res_fwd_next;
        end
    end

    // store addresses need no reset, the valid bits guard them
    always_ff @(posedge aclk) begin
        if (cmd.commit && is_store) begin
            saddr_reg[sslot_reg] <= addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LOAD_ENTRIES; i++) begin
                lrel_reg[i] <= '0;
            end
            for (int i = 0; i < STORE_ENTRIES; i++) begin
                srel_reg[i] <= '0;
            end
            svalid_reg    <= '0;
            lslot_reg     <= '0;
            sslot_reg     <= '0;
            lfence_reg    <= '0;
            sfence_reg    <= '0;
            last_lrel_reg <= '0;
            last_srel_reg <= '0;
        end else if (cmd.commit) begin
            case (op_t'(op_reg))
                OP_LOAD: begin
                    lrel_reg[lslot_reg] <= res_rel_next;
                    last_lrel_reg       <= res_rel_next;
                    lslot_reg           <= (lslot_reg == LQ_LAST) ? '0 : lslot_reg + 1'b1;
                end
                OP_STORE: begin
                    srel_reg[sslot_reg]   <= res_rel_next;
                    svalid_reg[sslot_reg] <= 1'b1;
                    last_srel_reg         <= res_rel_next;
                    sslot_reg             <= (sslot_reg == SQ_LAST) ? '0 : sslot_reg + 1'b1;
                end
                OP_LFENCE: lfence_reg <= prevl_reg;
                OP_SFENCE: sfence_reg <= prevs_reg;
                OP_FENCE: begin
                    lfence_reg <= pm_reg;
                    sfence_reg <= pm_reg;
                end
                default: begin
                    lfence_reg <= lfence_reg;
                end
            endcase
        end
    end

    assign m_grant_time   = res_alloc_reg;
    assign m_finish_time  = res_comp_reg;
    assign m_release_time = res_rel_reg;
    assign m_forwarded    = res_fwd_reg;

endmodule

>>> rtl/load_store_queue_timing_top.sv
`timescale 1ns / 1ps
// top level: configuration registers, controller and datapath
// depends on lsqt_pkg, lsqt_ctrl, lsqt_datapath

// Load/store queue timing model. Each request (load, store or one of three
// fences) yields exactly one result. After acceptance the controller steps it
// through slot allocation, fence and store-address match, the latency sum and
// the commit, one step per cycle, and takes a new request only after the
// commit. The result sits in an output register, so a new request enters while
// the last result waits; the commit of the next one holds until that register
// drains. The two mode registers (speculative loads at 0x0, parallel store
// ownership at 0x4, both reset to 1) should be written only while no request
// is open.

module load_store_queue_timing_top import lsqt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [TIME_W-1:0]     s_request_time,
    input  logic [LAT_W-1:0]      s_latency,
    input  logic [ADDR_W-1:0]     s_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TIME_W-1:0]     m_grant_time,
    output logic [TIME_W-1:0]     m_finish_time,
    output logic [TIME_W-1:0]     m_release_time,
    output logic                  m_forwarded
);

    lsqt_cmd_t cmd;
    logic      spec_reg, par_reg;
    logic      cfg_write;
    reg_idx_t  cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spec_reg <= 1'b1;
            par_reg  <= 1'b1;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_SPECULATIVE_LOADS: spec_reg <= pwdata[0];
                REG_PARALLEL_STORES:   par_reg  <= pwdata[0];
                default:               spec_reg <= spec_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_SPECULATIVE_LOADS: prdata = {{(CFG_DATA_W-1){1'b0}}, spec_reg};
            REG_PARALLEL_STORES:   prdata = {{(CFG_DATA_W-1){1'b0}}, par_reg};
            default:               prdata = '0;
        endcase
    end

    lsqt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lsqt_datapath u_datapath (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .cmd                      (cmd),
        .speculative_loads        (spec_reg),
        .parallel_store_ownership (par_reg),
        .s_operation              (s_operation),
        .s_request_time           (s_request_time),
        .s_latency                (s_latency),
        .s_address                (s_address),
        .m_grant_time             (m_grant_time),
        .m_finish_time            (m_finish_time),
        .m_release_time           (m_release_time),
        .m_forwarded              (m_forwarded)
    );

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a new result only comes from a commit
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.commit))
        else $error("result appeared without a commit");

    // a forwarded load's finish time is its grant time plus one
    a_forward_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_forwarded |-> m_finish_time == sat_add(m_grant_time, TIME_ONE))
        else $error("forwarded load completion mismatch");

endmodule

>>> verif/lsqt_timing_checker.sv
`timescale 1ns / 1ps
// checker for the load/store queue timing block: follows mode register writes,
// predicts one timing result per request and compares it with the result channel
// depends on lsqt_pkg

module lsqt_timing_checker import lsqt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [TIME_W-1:0]     s_request_time,
    input  logic [LAT_W-1:0]      s_latency,
    input  logic [ADDR_W-1:0]     s_address,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [TIME_W-1:0]     m_grant_time,
    input  logic [TIME_W-1:0]     m_finish_time,
    input  logic [TIME_W-1:0]     m_release_time,
    input  logic                  m_forwarded,
    output int                    pending_results,
    output int                    mismatch_count
);

    typedef struct packed {
        time_t alloc_at;
        time_t done_at;
        time_t freed_at;
        logic  forwarded;
    } timing_result_t;

    time_t               ld_release [LOAD_ENTRIES];
    logic [LQ_IDX_W-1:0] ld_slot;
    time_t               ld_fence;
    time_t               st_release [STORE_ENTRIES];
    time_t               st_addr [STORE_ENTRIES];
    logic                st_live [STORE_ENTRIES];
    logic [SQ_IDX_W-1:0] st_slot;
    time_t               st_fence;
    logic                spec_mode;
    logic                parallel_mode;
    timing_result_t      expected_timing[$];
    int                  mismatches;

    function automatic time_t clamped_sum(time_t a, time_t b);
        logic [TIME_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        if (wide > {1'b0, TIME_MAX})
            return TIME_MAX;
        return wide[TIME_W-1:0];
    endfunction

    function automatic time_t later_of(time_t a, time_t b);
        return (a >= b) ? a : b;
    endfunction

    // works out the result of one request and advances the queue state
    function automatic timing_result_t predict_timing(logic [OP_W-1:0] op, time_t req,
                                                      logic [LAT_W-1:0] lat, time_t addr);
        timing_result_t      r;
        time_t               prev_ld;
        time_t               prev_st;
        time_t               issue;
        time_t               step;
        time_t               sum;
        logic                hit;
        logic [LQ_IDX_W-1:0] ld_prev_idx;
        logic [SQ_IDX_W-1:0] st_prev_idx;
        r = '0;
        hit = 1'b0;
        step = time_t'(lat);
        ld_prev_idx = (ld_slot == '0) ? LQ_LAST : ld_slot - 1'b1;
        st_prev_idx = (st_slot == '0) ? SQ_LAST : st_slot - 1'b1;
        prev_ld = ld_release[ld_prev_idx];
        prev_st = st_release[st_prev_idx];
        case (op)
            OP_LOAD: begin
                r.alloc_at = later_of(clamped_sum(ld_release[ld_slot], TIME_ONE), req);
                for (int i = 0; i < STORE_ENTRIES; i++) begin
                    if (st_live[i] && st_addr[i] == addr && st_release[i] >= r.alloc_at)
                        hit = 1'b1;
                end
                if (hit)
                    step = TIME_ONE;
                issue = later_of(r.alloc_at, ld_fence);
                if (spec_mode) begin
                    sum = clamped_sum(issue, step);
                    r.done_at = sum;
                    r.freed_at = later_of(sum, clamped_sum(prev_ld, TIME_ONE));
                end else begin
                    issue = later_of(issue, prev_ld);
                    r.done_at = clamped_sum(issue, step);
                    r.freed_at = r.done_at;
                end
                // forwarded data is ready at the alloc time plus one
                if (hit)
                    r.done_at = clamped_sum(r.alloc_at, TIME_ONE);
                r.forwarded = hit;
                ld_release[ld_slot] = r.freed_at;
                ld_slot = (ld_slot == LQ_LAST) ? '0 : ld_slot + 1'b1;
            end
            OP_STORE: begin
                r.alloc_at = later_of(clamped_sum(st_release[st_slot], TIME_ONE), req);
                issue = later_of(r.alloc_at, st_fence);
                if (parallel_mode)
                    r.freed_at = clamped_sum(later_of(later_of(clamped_sum(issue, step),
                                                               prev_st), prev_ld), TIME_ONE);
                else
                    r.freed_at = clamped_sum(later_of(later_of(issue, prev_st), prev_ld), step);
                r.done_at = r.freed_at;
                st_release[st_slot] = r.freed_at;
                st_addr[st_slot] = addr;
                st_live[st_slot] = 1'b1;
                st_slot = (st_slot == SQ_LAST) ? '0 : st_slot + 1'b1;
            end
            OP_LFENCE: ld_fence = prev_ld;
            OP_SFENCE: st_fence = prev_st;
            OP_FENCE: begin
                ld_fence = later_of(prev_ld, prev_st);
                st_fence = ld_fence;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int field_mismatch(string name, time_t want, time_t got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : track
        timing_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < LOAD_ENTRIES; i++)
                ld_release[i] = '0;
            for (int i = 0; i < STORE_ENTRIES; i++) begin
                st_release[i] = '0;
                st_addr[i] = '0;
                st_live[i] = 1'b0;
            end
            ld_slot = '0;
            st_slot = '0;
            ld_fence = '0;
            st_fence = '0;
            spec_mode = 1'b1;
            parallel_mode = 1'b1;
            expected_timing.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
                    REG_SPECULATIVE_LOADS: spec_mode = pwdata[0];
                    REG_PARALLEL_STORES:   parallel_mode = pwdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_timing.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_timing.pop_front();
                    mismatches += field_mismatch("grant_time", want.alloc_at,
                                                 m_grant_time);
                    mismatches += field_mismatch("finish_time", want.done_at,
                                                 m_finish_time);
                    mismatches += field_mismatch("release_time", want.freed_at,
                                                 m_release_time);
                    mismatches += field_mismatch("forwarded", time_t'(want.forwarded),
                                                 time_t'(m_forwarded));
                end
            end
            if (s_valid && s_ready)
                expected_timing.push_back(predict_timing(s_operation, s_request_time,
                                                         s_latency, s_address));
        end
        pending_results <= expected_timing.size();
        mismatch_count <= mismatches;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the load/store queue timing block: clock, reset, mode register
// writes, request stimulus with random idling, watchdog and verdict
// depends on lsqt_pkg, load_store_queue_timing_top, lsqt_timing_checker

module tb_top import lsqt_pkg::*; ();

    localparam int STALL_LIMIT     = 20000;
    localparam int SEGMENT_ITEMS   = 90;
    localparam int SETTLE_CYCLES   = 20;
    localparam logic [OP_W-1:0] OP_CODE_TOP = '1;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation = '0;
    logic [TIME_W-1:0]     s_request_time = '0;
    logic [LAT_W-1:0]      s_latency = '0;
    logic [ADDR_W-1:0]     s_address = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [TIME_W-1:0]     m_grant_time;
    logic [TIME_W-1:0]     m_finish_time;
    logic [TIME_W-1:0]     m_release_time;
    logic                  m_forwarded;

    int    pending_results;
    int    mismatch_count;
    int    stall_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    time_t now_base;
    time_t addr_pool [4];

    load_store_queue_timing_top DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_request_time    (s_request_time),
        .s_latency         (s_latency),
        .s_address         (s_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_grant_time      (m_grant_time),
        .m_finish_time     (m_finish_time),
        .m_release_time    (m_release_time),
        .m_forwarded       (m_forwarded)
    );

    lsqt_timing_checker timing_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_request_time    (s_request_time),
        .s_latency         (s_latency),
        .s_address         (s_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_grant_time      (m_grant_time),
        .m_finish_time     (m_finish_time),
        .m_release_time    (m_release_time),
        .m_forwarded       (m_forwarded),
        .pending_results   (pending_results),
        .mismatch_count    (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("load_store_queue_timing_top regression: fail");
        $finish;
    end

    function automatic time_t rand_time();
        return time_t'({$urandom, $urandom});
    endfunction

    task automatic drive_request(input logic [OP_W-1:0] op, input time_t req,
                                 input logic [LAT_W-1:0] lat, input time_t addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_request_time <= req;
        s_latency <= lat;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off new requests until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic write_mode_reg(input reg_idx_t idx, input logic value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00});
        pwdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_request();
        int               pick;
        logic [OP_W-1:0]  op;
        time_t            req;
        logic [LAT_W-1:0] lat;
        time_t            addr;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_LOAD;
        else if (pick < 80)
            op = OP_STORE;
        else if (pick < 85)
            op = OP_LFENCE;
        else if (pick < 90)
            op = OP_SFENCE;
        else if (pick < 95)
            op = OP_FENCE;
        else
            op = OP_W'($urandom_range(int'(OP_FENCE) + 1, int'(OP_CODE_TOP)));
        // dispatch time mostly creeps forward, with the odd jump past the queues
        if ($urandom_range(0, 39) == 0)
            now_base = now_base + time_t'($urandom_range(1000, 80000));
        else
            now_base = now_base + time_t'($urandom_range(0, 6));
        pick = $urandom_range(0, 9);
        if (pick < 8)
            req = now_base + time_t'($urandom_range(0, 20));
        else
            req = now_base >> $urandom_range(1, 12);
        if ($urandom_range(0, 29) == 0)
            lat = LAT_W'($urandom);
        else
            lat = LAT_W'($urandom_range(0, 40));
        if ($urandom_range(0, 4) != 0)
            addr = addr_pool[$urandom_range(0, 3)];
        else
            addr = rand_time();
        drive_request(op, req, lat, addr);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        now_base = '0;
        foreach (addr_pool[i])
            addr_pool[i] = rand_time();

        // directed part, reset modes: speculative loads, parallel stores
        drive_request(OP_LOAD, '0, '0, '0);
        drive_request(OP_LOAD, '0, '0, TIME_MAX);
        drive_request(OP_STORE, time_t'(20), LAT_W'(10), addr_pool[0]);
        drive_request(OP_LOAD, time_t'(21), LAT_W'(25), addr_pool[0]);
        drive_request(OP_LOAD, time_t'(22), LAT_W'(7), addr_pool[1]);
        drive_request(OP_STORE, time_t'(30), '0, addr_pool[1]);
        drive_request(OP_LFENCE, rand_time(), LAT_W'($urandom), rand_time());
        drive_request(OP_LOAD, time_t'(25), LAT_W'(3), addr_pool[2]);
        drive_request(OP_SFENCE, rand_time(), LAT_W'($urandom), rand_time());
        drive_request(OP_STORE, time_t'(40), '1, addr_pool[0]);
        drive_request(OP_LOAD, time_t'(41), LAT_W'(2), addr_pool[0]);
        drive_request(OP_FENCE, rand_time(), LAT_W'($urandom), rand_time());
        drive_request(OP_LOAD, '0, LAT_W'(1), addr_pool[3]);
        drive_request(OP_STORE, '0, LAT_W'(4), addr_pool[3]);
        for (int code = int'(OP_FENCE) + 1; code <= int'(OP_CODE_TOP); code++)
            drive_request(OP_W'(code), rand_time(), LAT_W'($urandom), rand_time());
        now_base = time_t'(100);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // walk all four mode combinations in every idling phase
            for (int modes = 1; modes <= 4; modes++) begin
                drain_results();
                write_mode_reg(REG_SPECULATIVE_LOADS, modes[0]);
                write_mode_reg(REG_PARALLEL_STORES, modes[1]);
                repeat (SEGMENT_ITEMS)
                    send_random_request();
            end
        end

        // saturating times go last since queue times never come back down
        drive_request(OP_STORE, TIME_MAX, '1, TIME_MAX);
        drive_request(OP_LOAD, TIME_MAX, '1, TIME_MAX);
        drive_request(OP_LOAD, TIME_MAX, '1, '0);
        drive_request(OP_FENCE, TIME_MAX, '1, TIME_MAX);
        drive_request(OP_STORE, '0, '1, '0);
        drive_request(OP_LOAD, '0, '0, addr_pool[1]);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("load_store_queue_timing_top regression: pass");
        else
            $display("load_store_queue_timing_top regression: fail");
        $finish;
    end

endmodule
